[design/hmr_pkg.sv]
// Shared types and constants for the histogram maximum rectangle block.
package hmr_pkg;

    localparam int MAX_BARS_DEFAULT    = 1024;
    localparam int HEIGHT_BITS_DEFAULT = 16;
    localparam int IN_HEIGHT_W         = 16;
    localparam int AREA_W              = 26;
    localparam int OUT_DATA_W          = 32;

    localparam logic [AREA_W-1:0] AREA_LIMIT = {AREA_W{1'b1}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMP,
        ST_POP_MUL,
        ST_SCORE,
        ST_FLUSH
    } hmr_state_t;

    typedef struct packed {
        logic mul_en;
        logic score_en;
        logic clear;
    } hmr_area_ctrl_t;

endpackage

[design/hmr_stack_ram.sv]
// Stack storage: one write port and one registered read port.
module hmr_stack_ram #(
    parameter int DEPTH  = hmr_pkg::MAX_BARS_DEFAULT,
    parameter int DATA_W = 26
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[design/hmr_area_unit.sv]
// Shared area unit: registered height-by-span multiply and running maximum.
module hmr_area_unit #(
    parameter int HEIGHT_BITS = hmr_pkg::HEIGHT_BITS_DEFAULT,
    parameter int CNT_W       = 11
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  hmr_pkg::hmr_area_ctrl_t      ctrl,
    input  logic [HEIGHT_BITS-1:0]       height,
    input  logic [CNT_W-1:0]             span,
    output logic [HEIGHT_BITS+CNT_W-1:0] best_area
);

    localparam int PROD_W = HEIGHT_BITS + CNT_W;

    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] best_reg;
    logic [PROD_W-1:0] best_next;

    always_ff @(posedge aclk) begin
        if (ctrl.mul_en) begin
            prod_reg <= PROD_W'(height) * PROD_W'(span);
        end
    end

    always_comb begin
        best_next = best_reg;
        if (ctrl.clear) begin
            best_next = '0;
        end else if (ctrl.score_en && (prod_reg > best_reg)) begin
            best_next = prod_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_reg <= '0;
        end else begin
            best_reg <= best_next;
        end
    end

    assign best_area = best_reg;

endmodule

[design/histogram_max_rectangle_stack_core.sv]
// Top level: sequencer and stack control for the largest rectangle in a histogram.
//
// Bars arrive one per request on the slave side; s_tlast marks the final bar, and one
// result with the largest area follows on the master side. The block takes one bar at a
// time and holds s_tready low while it works. Each bar is accepted and compared, pops
// every taller stacked bar and is then pushed; the final bar then pops every entry left
// on the stack and posts the result once the output is free. A pop runs through the
// registered stack read, the shared multiplier and the maximum compare in that order.
// Bars past MAX_BARS are dropped and set the overflow flag. The top of the stack lives in
// registers, and every entry is also written to a memory with a single read port.
module histogram_max_rectangle_stack_core #(
    parameter int MAX_BARS    = hmr_pkg::MAX_BARS_DEFAULT,
    parameter int HEIGHT_BITS = hmr_pkg::HEIGHT_BITS_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [hmr_pkg::IN_HEIGHT_W-1:0] s_tdata,  // [15:0] bar_height
    input  logic                            s_tlast,  // last_bar
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [hmr_pkg::OUT_DATA_W-1:0]  m_tdata   // [25:0] max_area, [26] overflow
);

    localparam int CNT_W  = $clog2(MAX_BARS + 1);
    localparam int ADDR_W = $clog2(MAX_BARS);
    localparam int PROD_W = HEIGHT_BITS + CNT_W;
    localparam int ENT_W  = ADDR_W + HEIGHT_BITS;
    localparam int CMP_W  = (PROD_W > hmr_pkg::AREA_W) ? PROD_W : hmr_pkg::AREA_W;
    localparam int WIDE_W = HEIGHT_BITS + hmr_pkg::IN_HEIGHT_W;

    hmr_pkg::hmr_state_t state_reg, state_next;

    logic [CNT_W-1:0]       depth_reg, depth_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   ovf_reg, ovf_next;
    logic                   flushing_reg, flushing_next;
    logic [HEIGHT_BITS-1:0] cur_h_reg, cur_h_next;
    logic                   last_reg, last_next;
    logic [HEIGHT_BITS-1:0] top_h_reg, top_h_next;
    logic [ADDR_W-1:0]      top_idx_reg, top_idx_next;
    logic                   m_valid_reg, m_valid_next;
    logic [hmr_pkg::AREA_W-1:0] m_area_reg, m_area_next;
    logic                   m_ovf_reg, m_ovf_next;

    logic [WIDE_W-1:0]      h_wide;
    logic [HEIGHT_BITS-1:0] h_in;
    logic                   wr_en;
    logic [ADDR_W-1:0]      wr_addr;
    logic [ENT_W-1:0]       wr_data;
    logic                   rd_en;
    logic [ADDR_W-1:0]      rd_addr;
    logic [ENT_W-1:0]       rd_data;
    logic [CNT_W-1:0]       below_pos;
    logic [ADDR_W-1:0]      below_idx;
    logic [HEIGHT_BITS-1:0] below_h;
    logic [CNT_W-1:0]       span;
    logic [PROD_W-1:0]      best_area;
    logic [CMP_W-1:0]       best_ext;
    logic [hmr_pkg::AREA_W-1:0] best_sat;
    logic                   out_free;
    hmr_pkg::hmr_area_ctrl_t area_ctrl;

    assign h_wide    = {{HEIGHT_BITS{1'b0}}, s_tdata};
    assign h_in      = h_wide[HEIGHT_BITS-1:0];
    assign below_pos = depth_reg - CNT_W'(2);
    assign below_idx = rd_data[ENT_W-1:HEIGHT_BITS];
    assign below_h   = rd_data[HEIGHT_BITS-1:0];
    assign span      = (depth_reg == CNT_W'(1)) ? count_reg
                     : count_reg - CNT_W'(below_idx) - CNT_W'(1);
    assign best_ext  = CMP_W'(best_area);
    assign best_sat  = (best_ext > CMP_W'(hmr_pkg::AREA_LIMIT)) ? hmr_pkg::AREA_LIMIT
                     : best_ext[hmr_pkg::AREA_W-1:0];
    assign out_free  = !m_valid_reg || m_tready;

    hmr_stack_ram #(
        .DEPTH  (MAX_BARS),
        .DATA_W (ENT_W)
    ) u_stack (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    hmr_area_unit #(
        .HEIGHT_BITS (HEIGHT_BITS),
        .CNT_W       (CNT_W)
    ) u_area (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (area_ctrl),
        .height    (top_h_reg),
        .span      (span),
        .best_area (best_area)
    );

    always_comb begin
        state_next    = state_reg;
        depth_next    = depth_reg;
        count_next    = count_reg;
        ovf_next      = ovf_reg;
        flushing_next = flushing_reg;
        cur_h_next    = cur_h_reg;
        last_next     = last_reg;
        top_h_next    = top_h_reg;
        top_idx_next  = top_idx_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_area_next   = m_area_reg;
        m_ovf_next    = m_ovf_reg;
        wr_en         = 1'b0;
        wr_addr       = depth_reg[ADDR_W-1:0];
        wr_data       = {count_reg[ADDR_W-1:0], cur_h_reg};
        rd_en         = 1'b0;
        rd_addr       = below_pos[ADDR_W-1:0];
        area_ctrl     = '0;
        s_tready      = 1'b0;

        unique case (state_reg)
            hmr_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cur_h_next = h_in;
                    last_next  = s_tlast;
                    if (count_reg < CNT_W'(MAX_BARS)) begin
                        state_next = hmr_pkg::ST_CMP;
                    end else begin
                        ovf_next = 1'b1;
                        if (s_tlast) begin
                            flushing_next = 1'b1;
                            state_next    = hmr_pkg::ST_FLUSH;
                        end
                    end
                end
            end
            hmr_pkg::ST_CMP: begin
                if ((depth_reg != '0) && (top_h_reg > cur_h_reg)) begin
                    rd_en      = 1'b1;
                    state_next = hmr_pkg::ST_POP_MUL;
                end else begin
                    wr_en        = 1'b1;
                    top_h_next   = cur_h_reg;
                    top_idx_next = count_reg[ADDR_W-1:0];
                    depth_next   = depth_reg + CNT_W'(1);
                    count_next   = count_reg + CNT_W'(1);
                    if (last_reg) begin
                        flushing_next = 1'b1;
                        state_next    = hmr_pkg::ST_FLUSH;
                    end else begin
                        state_next = hmr_pkg::ST_IDLE;
                    end
                end
            end
            hmr_pkg::ST_POP_MUL: begin
                area_ctrl.mul_en = 1'b1;
                top_h_next       = below_h;
                top_idx_next     = below_idx;
                depth_next       = depth_reg - CNT_W'(1);
                state_next       = hmr_pkg::ST_SCORE;
            end
            hmr_pkg::ST_SCORE: begin
                area_ctrl.score_en = 1'b1;
                state_next = flushing_reg ? hmr_pkg::ST_FLUSH : hmr_pkg::ST_CMP;
            end
            hmr_pkg::ST_FLUSH: begin
                if (depth_reg != '0) begin
                    rd_en      = 1'b1;
                    state_next = hmr_pkg::ST_POP_MUL;
                end else if (out_free) begin
                    m_valid_next    = 1'b1;
                    m_area_next     = best_sat;
                    m_ovf_next      = ovf_reg;
                    area_ctrl.clear = 1'b1;
                    count_next      = '0;
                    ovf_next        = 1'b0;
                    flushing_next   = 1'b0;
                    state_next      = hmr_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = hmr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= hmr_pkg::ST_IDLE;
            depth_reg    <= '0;
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
            flushing_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            depth_reg    <= depth_next;
            count_reg    <= count_next;
            ovf_reg      <= ovf_next;
            flushing_reg <= flushing_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_h_reg   <= cur_h_next;
        last_reg    <= last_next;
        top_h_reg   <= top_h_next;
        top_idx_reg <= top_idx_next;
        m_area_reg  <= m_area_next;
        m_ovf_reg   <= m_ovf_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = hmr_pkg::OUT_DATA_W'({m_ovf_reg, m_area_reg});

    a_depth_within_count: assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= count_reg)
        else $error("Stack depth exceeds the number of stacked bars.");

    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_BARS))
        else $error("Bar count exceeds the stack capacity.");

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == hmr_pkg::ST_POP_MUL) |-> (depth_reg != '0))
        else $error("Pop issued on an empty stack.");

    a_clean_after_result: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ((depth_reg == '0) && (count_reg == '0) && !ovf_reg))
        else $error("Histogram state not cleared after the result was posted.");

endmodule

[dv/histogram_max_rectangle_stack_monitor.sv]
`timescale 1ns / 1ps
// Monitor that predicts the largest histogram rectangle and checks every posted result.
module histogram_max_rectangle_stack_monitor #(
    parameter int MAX_BARS    = hmr_pkg::MAX_BARS_DEFAULT,
    parameter int HEIGHT_BITS = hmr_pkg::HEIGHT_BITS_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [hmr_pkg::IN_HEIGHT_W-1:0] s_tdata,  // [15:0] bar_height
    input  logic                            s_tlast,  // last_bar
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [hmr_pkg::OUT_DATA_W-1:0]  m_tdata,  // [25:0] max_area, [26] overflow
    output int                              fail_count,
    output int                              pending_results,
    output int                              bars_accepted,
    output int                              histograms_checked
);
    import hmr_pkg::*;

    typedef struct packed {
        logic [AREA_W-1:0] area;
        logic              overflow;
    } area_result_t;

    longint unsigned stack_heights [MAX_BARS];
    int unsigned     stack_indexes [MAX_BARS];
    int unsigned     stack_fill;
    int unsigned     bars_in_histogram;
    longint unsigned best_so_far;
    bit              dropped_bars;
    area_result_t    expected_areas [$];

    initial begin
        fail_count         = 0;
        pending_results    = 0;
        bars_accepted      = 0;
        histograms_checked = 0;
        stack_fill         = 0;
        bars_in_histogram  = 0;
        best_so_far        = 0;
        dropped_bars       = 1'b0;
    end

    task automatic close_top(input int unsigned right_edge);
        longint unsigned height;
        longint unsigned area;
        int unsigned     left_edge;
        stack_fill--;
        height    = stack_heights[stack_fill];
        left_edge = (stack_fill == 0) ? 0 : stack_indexes[stack_fill - 1] + 1;
        area      = (right_edge >= left_edge) ? height * (right_edge - left_edge) : 0;
        if (area > best_so_far) begin
            best_so_far = area;
        end
    endtask

    task automatic fold_bar(input logic [IN_HEIGHT_W-1:0] raw, input logic last);
        longint unsigned height;
        area_result_t    res;
        height = 64'(raw) & ((64'd1 << HEIGHT_BITS) - 64'd1);
        if (bars_in_histogram < MAX_BARS) begin
            while (stack_fill > 0 && stack_heights[stack_fill - 1] > height) begin
                close_top(bars_in_histogram);
            end
            stack_heights[stack_fill] = height;
            stack_indexes[stack_fill] = bars_in_histogram;
            stack_fill++;
            bars_in_histogram++;
        end else begin
            dropped_bars = 1'b1;
        end
        if (last) begin
            while (stack_fill > 0) begin
                close_top(bars_in_histogram);
            end
            res.area     = (best_so_far > AREA_LIMIT) ? AREA_LIMIT : best_so_far[AREA_W-1:0];
            res.overflow = dropped_bars;
            expected_areas.push_back(res);
            stack_fill        = 0;
            bars_in_histogram = 0;
            best_so_far       = 0;
            dropped_bars      = 1'b0;
        end
    endtask

    always @(posedge aclk) begin
        area_result_t want;
        logic         bad;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                bars_accepted++;
                fold_bar(s_tdata, s_tlast);
            end
            if (m_tvalid && m_tready) begin
                if (expected_areas.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("Unexpected result: area %0d overflow %0b",
                                 m_tdata[AREA_W-1:0], m_tdata[AREA_W]);
                    end
                end else begin
                    want = expected_areas.pop_front();
                    histograms_checked++;
                    bad = (m_tdata[AREA_W-1:0] !== want.area) ||
                          (m_tdata[AREA_W] !== want.overflow) ||
                          (m_tdata[OUT_DATA_W-1:AREA_W+1] !== '0);
                    if (bad) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("Mismatch: expected area %0d overflow %0b, got tdata %h",
                                     want.area, want.overflow, m_tdata);
                        end
                    end
                end
            end
            pending_results = expected_areas.size();
        end
    end

endmodule

[dv/histogram_max_rectangle_stack_core_test.sv]
`timescale 1ns / 1ps
// Top of the testbench: clock, reset, bar stimulus, result back-pressure and the verdict.
module histogram_max_rectangle_stack_core_test;
    import hmr_pkg::*;

    localparam int MAX_BARS       = MAX_BARS_DEFAULT;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES    = 600;
    localparam int BARS_PER_PHASE = 110;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_HEIGHT_W-1:0] s_tdata  = '0;
    logic                   s_tlast  = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_tdata;

    int fail_count;
    int pending_results;
    int bars_accepted;
    int histograms_checked;

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    bit rx_hold      = 1'b0;

    histogram_max_rectangle_stack_core #(
        .MAX_BARS(MAX_BARS)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    histogram_max_rectangle_stack_monitor #(
        .MAX_BARS(MAX_BARS)
    ) area_monitor (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_tvalid          (s_tvalid),
        .s_tready          (s_tready),
        .s_tdata           (s_tdata),
        .s_tlast           (s_tlast),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .m_tdata           (m_tdata),
        .fail_count        (fail_count),
        .pending_results   (pending_results),
        .bars_accepted     (bars_accepted),
        .histograms_checked(histograms_checked)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    initial begin
        forever begin
            @(posedge aclk);
            if (rx_hold) begin
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT) begin
                    $display("Watchdog expired with %0d results outstanding.", pending_results);
                    $display("histogram_max_rectangle_stack_core test failed");
                    $finish;
                end
            end
        end
    end

    task automatic send_bar(input logic [IN_HEIGHT_W-1:0] height, input logic last);
        if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < tx_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= height;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_random_histogram(input int unsigned bars);
        int unsigned                style;
        int unsigned                base;
        logic [IN_HEIGHT_W-1:0]     height;
        style = $urandom_range(4);
        base  = $urandom_range(65535);
        for (int unsigned i = 0; i < bars; i++) begin
            case (style)
                0: height = IN_HEIGHT_W'($urandom_range(65535));
                1: height = IN_HEIGHT_W'($urandom_range(7));
                2: height = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                3: height = IN_HEIGHT_W'(base + i * $urandom_range(3));
                default: height = (base > i * 97) ? IN_HEIGHT_W'(base - i * 97)
                                                  : IN_HEIGHT_W'($urandom_range(15));
            endcase
            send_bar(height, i == bars - 1);
        end
    endtask

    initial begin
        int pair_heights [6] = '{2, 1, 5, 6, 2, 3};
        int phase_tx [4]     = '{0, 65, 0, 7};
        int phase_rx [4]     = '{0, 0, 65, 7};
        int phase_start;
        int bars;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_bar(16'h0000, 1'b1);
        send_bar(16'hFFFF, 1'b1);
        send_bar(16'hFFFF, 1'b0);
        send_bar(16'hFFFF, 1'b1);
        foreach (pair_heights[i]) begin
            send_bar(IN_HEIGHT_W'(pair_heights[i]), i == 5);
        end
        for (int i = 5; i >= 1; i--) begin
            send_bar(IN_HEIGHT_W'(i), i == 1);
        end
        for (int i = 1; i <= 4; i++) begin
            send_bar(IN_HEIGHT_W'(i), i == 4);
        end
        send_bar(16'd7, 1'b0);
        send_bar(16'd7, 1'b0);
        send_bar(16'd7, 1'b1);
        send_bar(16'd3, 1'b0);
        send_bar(16'd0, 1'b0);
        send_bar(16'd3, 1'b1);

        // A full stack of the tallest bars gives the largest area there is; the two
        // bars after it are dropped, the second of them carrying the last flag.
        for (int i = 0; i < MAX_BARS + 2; i++) begin
            send_bar(16'hFFFF, i == MAX_BARS + 1);
        end

        for (int p = 0; p < 4; p++) begin
            tx_idle_pct = phase_tx[p];
            rx_stall_pct <= phase_rx[p];
            if (p == 0) begin
                fork
                    begin
                        rx_hold <= 1'b1;
                        repeat (HOLD_CYCLES) @(posedge aclk);
                        rx_hold <= 1'b0;
                    end
                join_none
            end
            phase_start = bars_accepted;
            while (bars_accepted - phase_start < BARS_PER_PHASE) begin
                bars = ($urandom_range(19) == 0) ? $urandom_range(13, 80) : $urandom_range(1, 12);
                send_random_histogram(bars);
            end
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results != 0) begin
            @(posedge aclk);
        end
        repeat (50) @(posedge aclk);

        $display("Checked %0d histograms built from %0d bars.", histograms_checked, bars_accepted);
        $display("Covered full and overflowing histograms, extreme heights and four idle mixes.");
        if (fail_count == 0 && pending_results == 0) begin
            $display("histogram_max_rectangle_stack_core test passed");
        end else begin
            $display("histogram_max_rectangle_stack_core test failed");
        end
        $finish;
    end

endmodule

[sim.f]
design/hmr_pkg.sv
design/hmr_stack_ram.sv
design/hmr_area_unit.sv
design/histogram_max_rectangle_stack_core.sv
dv/histogram_max_rectangle_stack_monitor.sv
dv/histogram_max_rectangle_stack_core_test.sv
